FILE: src/ssd_pkg.sv
// Shared types, constants and decimal helpers for the seven-segment scan driver.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ssd_pkg;

    typedef enum logic [2:0] {
        OP_TEMPO  = 3'd0,
        OP_VOLUME = 3'd1,
        OP_PITCH  = 3'd2,
        OP_STOP   = 3'd3,
        OP_DP     = 3'd4,
        OP_TICK   = 3'd5
    } op_t;

    localparam int FRAME_BITS = 16;
    localparam int CNT_W      = $clog2(FRAME_BITS);
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [9:0] TEMPO_MAX = 10'd999;
    localparam logic [9:0] MIDI_MAX  = 10'd127;

    localparam logic [7:0] BLANK_GLYPH = 8'hFF;
    localparam logic [7:0] DASH_GLYPH  = 8'hBF;

    localparam logic [7:0] DIGIT_GLYPH [0:9] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };
    localparam logic [7:0] PREFIX_GLYPH [0:2] = '{8'h87, 8'hE3, 8'h8C};

    localparam logic [9:0] HUNDRED_STEP [0:9] = '{
        10'd0, 10'd100, 10'd200, 10'd300, 10'd400,
        10'd500, 10'd600, 10'd700, 10'd800, 10'd900
    };
    localparam logic [6:0] TEN_STEP [0:9] = '{
        7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90
    };

    typedef struct packed {
        logic [FRAME_BITS-1:0] bits;
        logic [1:0]            digit;
    } frame_t;

    function automatic logic [3:0] div100(input logic [9:0] v);
        logic [3:0] q;
        q = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (v >= HUNDRED_STEP[k]) begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

    function automatic logic [3:0] div10(input logic [6:0] v);
        logic [3:0] q;
        q = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (v >= TEN_STEP[k]) begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

    function automatic logic [7:0] select_byte(input logic [1:0] d);
        return 8'(8'd8 >> d);
    endfunction

endpackage

`default_nettype wire

FILE: src/ssd_front.sv
// Front part: accepts words, keeps the segment buffer and scan digit, and
// queues refresh frames. Depends on ssd_pkg.
`default_nettype none

module ssd_front
    import ssd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  op,
    input  wire logic [15:0] value,
    input  wire logic [7:0]  position,
    input  wire logic        dp_on,
    output logic             fq_push,
    input  wire logic        fq_full,
    output frame_t           fq_word
);

    logic       s_valid_reg, s_valid_next;
    logic [2:0] s_op_reg;
    logic [3:0] s_hund_reg;
    logic [6:0] s_rem_reg;
    logic [7:0] s_pos_reg;
    logic       s_dp_reg;

    logic [6:0] glyph_reg [4];
    logic [6:0] glyph_next [4];
    logic [3:0] dark_reg, dark_next;
    logic [1:0] scan_reg, scan_next;

    logic       accept;
    logic       advance;
    logic [9:0] limit;
    logic [9:0] clamped;
    logic [3:0] in_hund;
    logic [3:0] tens;
    logic [3:0] ones;
    logic [7:0] g1, g2, g3;

    assign advance = !(op_t'(s_op_reg) == OP_TICK && fq_full);
    assign full    = s_valid_reg && !advance;
    assign accept  = push && !full;

    assign limit   = (op == OP_TEMPO) ? TEMPO_MAX : MIDI_MAX;
    assign clamped = (value > {6'd0, limit}) ? limit : value[9:0];
    assign in_hund = div100(clamped);

    assign s_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_op_reg   <= op;
            s_hund_reg <= in_hund;
            s_rem_reg  <= 7'(clamped - HUNDRED_STEP[in_hund]);
            s_pos_reg  <= position;
            s_dp_reg   <= dp_on;
        end
    end

    assign tens = div10(s_rem_reg);
    assign ones = 4'(s_rem_reg - TEN_STEP[tens]);
    assign g1   = (s_hund_reg == 4'd0) ? BLANK_GLYPH : DIGIT_GLYPH[s_hund_reg];
    assign g2   = (s_hund_reg == 4'd0 && s_rem_reg < 7'd10) ? BLANK_GLYPH
                                                            : DIGIT_GLYPH[tens];
    assign g3   = DIGIT_GLYPH[ones];

    always_comb
    begin
        glyph_next = glyph_reg;
        dark_next  = dark_reg;
        scan_next  = scan_reg;
        fq_push    = 1'b0;
        if (s_valid_reg && advance)
        begin
            unique case (op_t'(s_op_reg))
                OP_TEMPO, OP_VOLUME, OP_PITCH:
                begin
                    glyph_next[0] = PREFIX_GLYPH[s_op_reg[1:0]][6:0];
                    glyph_next[1] = g1[6:0];
                    glyph_next[2] = g2[6:0];
                    glyph_next[3] = g3[6:0];
                    dark_next     = 4'hF;
                end
                OP_STOP:
                begin
                    glyph_next[0] = DASH_GLYPH[6:0];
                    glyph_next[1] = BLANK_GLYPH[6:0];
                    glyph_next[2] = BLANK_GLYPH[6:0];
                    glyph_next[3] = BLANK_GLYPH[6:0];
                    dark_next     = 4'hF;
                end
                OP_DP:
                begin
                    if (s_pos_reg < 8'd4)
                    begin
                        dark_next[s_pos_reg[1:0]] = !s_dp_reg;
                    end
                end
                OP_TICK:
                begin
                    fq_push   = 1'b1;
                    scan_next = 2'(scan_reg + 2'd1);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign fq_word.bits  = {dark_reg[scan_reg], glyph_reg[scan_reg], select_byte(scan_reg)};
    assign fq_word.digit = scan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                glyph_reg[i] <= BLANK_GLYPH[6:0];
            end
            dark_reg <= 4'hF;
            scan_reg <= 2'd0;
        end
        else
        begin
            glyph_reg <= glyph_next;
            dark_reg  <= dark_next;
            scan_reg  <= scan_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/ssd_fifo.sv
// Short frame queue between the front and back parts.
// Depends on ssd_pkg for the frame type and depth.
`default_nettype none

module ssd_fifo
    import ssd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr_en,
    input  wire frame_t wr_word,
    output logic        fifo_full,
    input  wire logic   rd_en,
    output frame_t      rd_word,
    output logic        fifo_empty
);

    frame_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  do_wr;
    logic                  do_rd;

    assign fifo_full  = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign fifo_empty = (cnt_reg == '0);
    assign do_wr      = wr_en && !fifo_full;
    assign do_rd      = rd_en && !fifo_empty;
    assign rd_word    = mem_reg[rd_ptr_reg];

    assign wr_ptr_next = do_wr ? FIFO_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
    assign rd_ptr_next = do_rd ? FIFO_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = FIFO_CNT_W'(cnt_reg + 1'b1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = FIFO_CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/ssd_back.sv
// Back part: serialises queued frames one bit per result word, MSB first.
// Depends on ssd_pkg for the frame type and bit count.
`default_nettype none

module ssd_back
    import ssd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire frame_t fq_word,
    input  wire logic   fq_empty,
    output logic        fq_pop,
    output logic        empty,
    input  wire logic   pop,
    output logic        serial_bit,
    output logic [1:0]  scan_position,
    output logic        last_bit
);

    logic                  busy_reg, busy_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [1:0]            digit_reg, digit_next;
    logic                  is_last;
    logic                  taken;

    assign is_last = (cnt_reg == CNT_W'(FRAME_BITS - 1));
    assign taken   = pop && busy_reg;
    assign fq_pop  = !fq_empty && (!busy_reg || (taken && is_last));

    always_comb
    begin
        busy_next  = busy_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        digit_next = digit_reg;
        if (fq_pop)
        begin
            busy_next  = 1'b1;
            shift_next = fq_word.bits;
            cnt_next   = '0;
            digit_next = fq_word.digit;
        end
        else if (taken)
        begin
            busy_next  = !is_last;
            shift_next = {shift_reg[FRAME_BITS-2:0], 1'b0};
            cnt_next   = CNT_W'(cnt_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        digit_reg <= digit_next;
    end

    assign empty         = !busy_reg;
    assign serial_bit    = shift_reg[FRAME_BITS-1];
    assign scan_position = digit_reg;
    assign last_bit      = is_last;

endmodule

`default_nettype wire

FILE: src/seven_segment_scan_driver_core.sv
// A refresh tick passes the input register, the frame queue and the serialiser's shift register
// before its first bit is offered. Display words are taken one per cycle unless a refresh tick
// is held by a full frame queue; ticks are limited by the serialiser, one bit per result word.
// A two-entry frame queue sits between the front and the serialiser.
// Reset (rst_n, asynchronous, active low) blanks all digits and sets the scan digit to 0.
// Top level of the scan driver; depends on ssd_pkg, ssd_front, ssd_fifo and ssd_back.
`default_nettype none

module seven_segment_scan_driver_core
    import ssd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  op,
    input  wire logic [15:0] value,
    input  wire logic [7:0]  position,
    input  wire logic        dp_on,
    output logic             empty,
    input  wire logic        pop,
    output logic             serial_bit,
    output logic [1:0]       scan_position,
    output logic             last_bit
);

    frame_t fq_in;
    frame_t fq_out;
    logic   fq_push;
    logic   fq_full;
    logic   fq_pop;
    logic   fq_empty;

    ssd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .op       (op),
        .value    (value),
        .position (position),
        .dp_on    (dp_on),
        .fq_push  (fq_push),
        .fq_full  (fq_full),
        .fq_word  (fq_in)
    );

    ssd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (fq_push),
        .wr_word    (fq_in),
        .fifo_full  (fq_full),
        .rd_en      (fq_pop),
        .rd_word    (fq_out),
        .fifo_empty (fq_empty)
    );

    ssd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .fq_word       (fq_out),
        .fq_empty      (fq_empty),
        .fq_pop        (fq_pop),
        .empty         (empty),
        .pop           (pop),
        .serial_bit    (serial_bit),
        .scan_position (scan_position),
        .last_bit      (last_bit)
    );

endmodule

`default_nettype wire
